@@ rtl/mcpi_pkg.sv @@
// Package for the motor current PI controller: payload structs, mode and
// register codes, fixed widths and the microcode program of the sequencer.
// No dependencies.
`default_nettype none

package mcpi_pkg;

  // Defaults of the top-level parameters
  localparam int TEST_LENGTH_DEF      = 100;
  localparam int INTEGRATOR_LIMIT_DEF = 2000;

  // Fixed datapath widths
  localparam int CUR_W    = 16;            // current in mA
  localparam int ERR_W    = CUR_W + 1;     // reference minus measured
  localparam int GAIN_W   = 16;            // Q8.8 gain
  localparam int PCT_W    = 8;             // open-loop percent
  localparam int PROD_W   = ERR_W + GAIN_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int MAG_W    = 15;            // |u| up to 100*256
  localparam int DUTY_W   = 11;
  localparam int CNT_W    = 7;
  localparam int SCALED_W = MAG_W + 5;     // |u| * 20

  localparam int U_LIMIT_Q   = 100 * 256;
  localparam int PCT_LIMIT   = 100;
  localparam int TEST_AMP    = 200;
  localparam int TEST_EDGE_1 = 25;
  localparam int TEST_EDGE_2 = 50;
  localparam int TEST_EDGE_3 = 75;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PWM   = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_TRACK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEGRAL_GAIN = 2'd1,
    REG_OPEN_LOOP     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                    func;
    mode_t                   new_mode;
    logic signed [CUR_W-1:0] measured_ma;
    logic signed [CUR_W-1:0] target_ma;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic                    direction;
    mode_t                   mode_now;
    logic signed [CUR_W-1:0] reference_ma;
    logic [CNT_W-1:0]        test_index;
    logic                    test_done;
  } result_t;

  // Microcode
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    OP_ERROR,   // pick reference, error = reference - measured
    OP_INTEG,   // integrator += error, clamp
    OP_MUL_P,   // acc = kp * error
    OP_MAC_I,   // acc += ki * integrator
    OP_SAT,     // clamp u, split into magnitude and direction
    OP_SCALE,   // duty = |u|*20 >> 8, test bookkeeping, emit
    OP_OPEN     // idle or pwm result, emit
  } op_t;

  typedef enum logic {
    COND_NEXT,
    COND_OPEN_LOOP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } mc_word_t;

  localparam step_t STEP_OPEN = step_t'(6);

  function automatic mc_word_t mc_rom(input step_t step);
    mc_word_t w;
    w = '{op: OP_OPEN, cond: COND_NEXT, target: '0, last: 1'b1};
    unique case (step)
      3'd0:    w = '{op: OP_ERROR, cond: COND_OPEN_LOOP, target: STEP_OPEN, last: 1'b0};
      3'd1:    w = '{op: OP_INTEG, cond: COND_NEXT, target: '0, last: 1'b0};
      3'd2:    w = '{op: OP_MUL_P, cond: COND_NEXT, target: '0, last: 1'b0};
      3'd3:    w = '{op: OP_MAC_I, cond: COND_NEXT, target: '0, last: 1'b0};
      3'd4:    w = '{op: OP_SAT,   cond: COND_NEXT, target: '0, last: 1'b0};
      3'd5:    w = '{op: OP_SCALE, cond: COND_NEXT, target: '0, last: 1'b1};
      3'd6:    w = '{op: OP_OPEN,  cond: COND_NEXT, target: '0, last: 1'b1};
      default: w = '{op: OP_OPEN,  cond: COND_NEXT, target: '0, last: 1'b1};
    endcase
    return w;
  endfunction

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic fire;   // current step executes this cycle
    op_t  op;
    logic emit;   // this step produces the result item
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/mcpi_sequencer.sv @@
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on mcpi_pkg.
`default_nettype none

module mcpi_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            open_loop,
  input  logic            emit_ok,
  output logic            busy,
  output mcpi_pkg::ctl_t  ctl
);

  mcpi_pkg::step_t    step;
  mcpi_pkg::mc_word_t word;
  logic               fire;

  assign word = mcpi_pkg::mc_rom(step);
  // the emitting step waits for room in the output register
  assign fire = busy && (!word.last || emit_ok);

  assign ctl.fire = fire;
  assign ctl.op   = word.op;
  assign ctl.emit = word.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fire) begin
      if (word.last) begin
        busy <= 1'b0;
      end else if (word.cond == mcpi_pkg::COND_OPEN_LOOP && open_loop) begin
        step <= word.target;
      end else begin
        step <= step + mcpi_pkg::step_t'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("sequencer restarted while busy");
  a_start_step0: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && step == '0)
    else $error("program did not begin at step zero");
  a_jump_open: assert property (@(posedge clk) disable iff (rst)
    fire && step == '0 && open_loop |=> step == mcpi_pkg::STEP_OPEN)
    else $error("open-loop dispatch missed");
`endif

endmodule

`default_nettype wire

@@ rtl/mcpi_datapath.sv @@
// Datapath: mode, test counter and integrator state, shared multiplier with
// accumulator, clamps and duty scaling. Driven by the sequencer control word.
// Depends on mcpi_pkg.
`default_nettype none

module mcpi_datapath #(
  parameter int TEST_LENGTH      = mcpi_pkg::TEST_LENGTH_DEF,
  parameter int INTEGRATOR_LIMIT = mcpi_pkg::INTEGRATOR_LIMIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  mcpi_pkg::in_t                         in_item,
  input  mcpi_pkg::ctl_t                        ctl,
  input  logic signed [mcpi_pkg::GAIN_W-1:0]    prop_gain,
  input  logic signed [mcpi_pkg::GAIN_W-1:0]    integral_gain,
  input  logic signed [mcpi_pkg::PCT_W-1:0]     open_loop_percent,
  output logic                                  open_loop,
  output mcpi_pkg::result_t                     result
);

  localparam int CUR_W    = mcpi_pkg::CUR_W;
  localparam int ERR_W    = mcpi_pkg::ERR_W;
  localparam int PROD_W   = mcpi_pkg::PROD_W;
  localparam int ACC_W    = mcpi_pkg::ACC_W;
  localparam int MAG_W    = mcpi_pkg::MAG_W;
  localparam int DUTY_W   = mcpi_pkg::DUTY_W;
  localparam int CNT_W    = mcpi_pkg::CNT_W;
  localparam int PCT_W    = mcpi_pkg::PCT_W;
  localparam int SCALED_W = mcpi_pkg::SCALED_W;
  localparam int INT_W    = $clog2(INTEGRATOR_LIMIT + 1) + 1;
  localparam int SUM_W    = ((INT_W > ERR_W) ? INT_W : ERR_W) + 1;

  localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(INTEGRATOR_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [ACC_W-1:0] U_POS   = ACC_W'(mcpi_pkg::U_LIMIT_Q);
  localparam logic signed [ACC_W-1:0] U_NEG   = -U_POS;
  localparam logic signed [PCT_W-1:0] P_POS   = PCT_W'(mcpi_pkg::PCT_LIMIT);
  localparam logic signed [PCT_W-1:0] P_NEG   = -P_POS;
  localparam logic signed [CUR_W-1:0] AMP_POS = CUR_W'(mcpi_pkg::TEST_AMP);
  localparam logic signed [CUR_W-1:0] AMP_NEG = -AMP_POS;
  localparam logic [CNT_W-1:0] EDGE_1   = CNT_W'(mcpi_pkg::TEST_EDGE_1);
  localparam logic [CNT_W-1:0] EDGE_2   = CNT_W'(mcpi_pkg::TEST_EDGE_2);
  localparam logic [CNT_W-1:0] EDGE_3   = CNT_W'(mcpi_pkg::TEST_EDGE_3);
  localparam logic [CNT_W-1:0] TEST_END = CNT_W'(TEST_LENGTH);

  // state
  mcpi_pkg::mode_t          mode;
  logic [CNT_W-1:0]         test_count;
  logic signed [INT_W-1:0]  integ;

  // working registers
  logic signed [CUR_W-1:0]  meas;
  logic signed [CUR_W-1:0]  target;
  logic signed [CUR_W-1:0]  ref_cur;
  logic signed [ERR_W-1:0]  err;
  logic signed [ACC_W-1:0]  acc;
  logic [MAG_W-1:0]         mag;
  logic                     dir;

  logic signed [CUR_W-1:0]  ref_sel;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [INT_W-1:0]  integ_clamped;
  logic signed [ERR_W-1:0]  mul_a;
  logic signed [mcpi_pkg::GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] product;
  logic [SCALED_W-1:0]      scaled;
  logic [DUTY_W-1:0]        duty_closed;
  logic signed [PCT_W-1:0]  pct_clamped;
  logic [PCT_W-1:0]         pct_abs;
  logic [DUTY_W-1:0]        duty_open;
  logic                     is_test;
  logic [CNT_W-1:0]         count_inc;
  logic                     test_end;

  assign open_loop = (mode == mcpi_pkg::MODE_IDLE) || (mode == mcpi_pkg::MODE_PWM);
  assign is_test   = (mode == mcpi_pkg::MODE_TEST);

  always_comb begin
    priority if (is_test) begin
      priority if (test_count >= EDGE_3)      ref_sel = AMP_NEG;
      else if (test_count >= EDGE_2)          ref_sel = AMP_POS;
      else if (test_count >= EDGE_1)          ref_sel = AMP_NEG;
      else                                    ref_sel = AMP_POS;
    end else if (mode == mcpi_pkg::MODE_TRACK) begin
      ref_sel = target;
    end else begin
      ref_sel = '0;
    end
  end

  assign integ_sum = SUM_W'(integ) + SUM_W'(err);
  always_comb begin
    priority if (integ_sum > LIM_POS) integ_clamped = INT_W'(LIM_POS);
    else if (integ_sum < LIM_NEG)     integ_clamped = INT_W'(LIM_NEG);
    else                              integ_clamped = INT_W'(integ_sum);
  end

  // one shared multiplier
  assign mul_a   = (ctl.op == mcpi_pkg::OP_MAC_I) ? ERR_W'(integ) : err;
  assign mul_b   = (ctl.op == mcpi_pkg::OP_MAC_I) ? integral_gain : prop_gain;
  assign product = mul_a * mul_b;

  assign scaled      = (SCALED_W'(mag) << 4) + (SCALED_W'(mag) << 2);
  assign duty_closed = DUTY_W'(scaled >> 8);

  always_comb begin
    priority if (open_loop_percent > P_POS) pct_clamped = P_POS;
    else if (open_loop_percent < P_NEG)     pct_clamped = P_NEG;
    else                                    pct_clamped = open_loop_percent;
  end
  assign pct_abs   = (pct_clamped > 0) ? pct_clamped : -pct_clamped;
  assign duty_open = (DUTY_W'(pct_abs) << 4) + (DUTY_W'(pct_abs) << 2);

  assign count_inc = test_count + CNT_W'(1);
  assign test_end  = is_test && (count_inc >= TEST_END);

  always_comb begin
    result = '0;
    if (ctl.op == mcpi_pkg::OP_OPEN) begin
      result.mode_now = mode;
      if (mode == mcpi_pkg::MODE_PWM) begin
        result.duty      = duty_open;
        result.direction = !(pct_clamped > 0);
      end
    end else begin
      result.duty         = duty_closed;
      result.direction    = dir;
      result.mode_now     = test_end ? mcpi_pkg::MODE_IDLE : mode;
      result.reference_ma = ref_cur;
      result.test_index   = is_test ? test_count : '0;
      result.test_done    = test_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mcpi_pkg::MODE_IDLE;
      test_count <= '0;
      integ      <= '0;
    end else if (start) begin
      meas   <= in_item.measured_ma;
      target <= in_item.target_ma;
      if (in_item.func) begin
        mode <= in_item.new_mode;
      end
    end else if (ctl.fire) begin
      unique case (ctl.op)
        mcpi_pkg::OP_ERROR: begin
          ref_cur <= ref_sel;
          err     <= ERR_W'(ref_sel) - ERR_W'(meas);
        end
        mcpi_pkg::OP_INTEG: integ <= integ_clamped;
        mcpi_pkg::OP_MUL_P: acc <= ACC_W'(product);
        mcpi_pkg::OP_MAC_I: acc <= acc + ACC_W'(product);
        mcpi_pkg::OP_SAT: begin
          priority if (acc > U_POS) begin
            mag <= MAG_W'(U_POS);
            dir <= 1'b0;
          end else if (acc < U_NEG) begin
            mag <= MAG_W'(U_POS);
            dir <= 1'b1;
          end else if (acc > 0) begin
            mag <= MAG_W'(acc);
            dir <= 1'b0;
          end else begin
            mag <= MAG_W'(-acc);
            dir <= 1'b1;
          end
        end
        mcpi_pkg::OP_SCALE: begin
          if (is_test) begin
            if (test_end) begin
              test_count <= '0;
              integ      <= '0;
              mode       <= mcpi_pkg::MODE_IDLE;
            end else begin
              test_count <= count_inc;
            end
          end
        end
        mcpi_pkg::OP_OPEN: begin
          // open-loop result comes straight from the config register
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/motor_current_pi_controller_unit.sv @@
// Top level of the motor current PI controller: configuration registers,
// handshakes and the output register around the sequencer and datapath.
// Depends on mcpi_pkg, mcpi_sequencer and mcpi_datapath.
//
// Usage:
//   in_*   : one control tick per item (func, new_mode, measured_ma, target_ma).
//   out_*  : one result item per tick (duty, direction, mode_now,
//            reference_ma, test_index, test_done).
//   cfg_*  : register writes: 0 prop_gain, 1 integral_gain,
//            2 open_loop_percent (low 8 bits); index 3 is ignored. Always ready.
// Timing: a closed-loop tick (test or track) runs six microcode steps and idle
//   and pwm ticks run two; a new item is taken only after the last step of the
//   previous tick has fired. The step count is set by the shared multiplier,
//   used once for the proportional and once for the integral term.
// Stall: a result waits in the output register; the next tick is accepted
//   and computed meanwhile, and only its final step waits for out_ready.
// Reset: mode returns to idle, the test count, integrator and all gains to 0;
//   no item is pending afterwards.
`default_nettype none

module motor_current_pi_controller_unit #(
  parameter int TEST_LENGTH      = mcpi_pkg::TEST_LENGTH_DEF,
  parameter int INTEGRATOR_LIMIT = mcpi_pkg::INTEGRATOR_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mcpi_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mcpi_pkg::result_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [mcpi_pkg::GAIN_W-1:0]        cfg_data
);

  logic signed [mcpi_pkg::GAIN_W-1:0] prop_gain;
  logic signed [mcpi_pkg::GAIN_W-1:0] integral_gain;
  logic signed [mcpi_pkg::PCT_W-1:0]  open_loop_percent;

  logic              busy;
  logic              start;
  logic              open_loop;
  logic              emit_ok;
  mcpi_pkg::ctl_t    ctl;
  mcpi_pkg::result_t result;

  assign in_ready  = !busy;
  assign start     = in_valid && in_ready;
  assign emit_ok   = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain         <= '0;
      integral_gain     <= '0;
      open_loop_percent <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mcpi_pkg::REG_PROP_GAIN:     prop_gain         <= cfg_data;
        mcpi_pkg::REG_INTEGRAL_GAIN: integral_gain     <= cfg_data;
        mcpi_pkg::REG_OPEN_LOOP:     open_loop_percent <= cfg_data[mcpi_pkg::PCT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  mcpi_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .open_loop (open_loop),
    .emit_ok   (emit_ok),
    .busy      (busy),
    .ctl       (ctl)
  );

  mcpi_datapath #(
    .TEST_LENGTH      (TEST_LENGTH),
    .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .in_item           (in_data),
    .ctl               (ctl),
    .prop_gain         (prop_gain),
    .integral_gain     (integral_gain),
    .open_loop_percent (open_loop_percent),
    .open_loop         (open_loop),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.fire && ctl.emit) begin
      out_valid <= 1'b1;
      out_data  <= result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.duty <= mcpi_pkg::DUTY_W'(2000))
    else $error("duty out of range");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while a tick is in progress");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.test_done |-> out_data.mode_now == mcpi_pkg::MODE_IDLE)
    else $error("test run ended without returning to idle");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode_now == mcpi_pkg::MODE_IDLE && !out_data.test_done
    |-> out_data.duty == '0 && out_data.reference_ma == '0)
    else $error("idle tick produced drive");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for motor_current_pi_controller_unit: queues control ticks, writes
// the gain and open-loop registers between phases, predicts every result item
// and checks it field by field. Depends on mcpi_pkg and the unit's RTL.
module tb;
  import mcpi_pkg::*;

  localparam int RUN_LIMIT     = 600000;
  localparam int RANDOM_TICKS  = 1400;
  localparam int SETTLE_CYCLES = 10;
  localparam int TEST_LEN      = TEST_LENGTH_DEF;
  localparam int INTEG_LIM     = INTEGRATOR_LIMIT_DEF;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  result_t           out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data  = '0;

  motor_current_pi_controller_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Controller copy: registers and state
  int    kp_q     = 0;
  int    ki_q     = 0;
  int    open_pct = 0;
  mode_t cur_mode = MODE_IDLE;
  int    test_cnt = 0;
  int    integ    = 0;

  in_t     tick_queue[$];
  result_t expected_results[$];
  int      ticks_queued = 0;
  int      ticks_taken  = 0;
  int      results_seen = 0;
  int      runs_done    = 0;
  int      cfg_writes   = 0;
  int      errors       = 0;
  int      cycles       = 0;
  int      send_gap     = 0;
  int      recv_stall   = 0;
  logic    calm         = 1'b0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  function automatic void pi_drive(input int ref_ma, input int meas_ma,
                                   output logic [DUTY_W-1:0] duty, output logic dir);
    int     err;
    longint u;
    err = ref_ma - meas_ma;
    integ += err;
    if (integ > INTEG_LIM) integ = INTEG_LIM;
    else if (integ < -INTEG_LIM) integ = -INTEG_LIM;
    u = longint'(kp_q) * err + longint'(ki_q) * integ;
    if (u > U_LIMIT_Q) u = U_LIMIT_Q;
    else if (u < -U_LIMIT_Q) u = -U_LIMIT_Q;
    dir = (u <= 0);
    if (u < 0) u = -u;
    duty = DUTY_W'((u * 20) >>> 8);
  endfunction

  function automatic result_t control_tick(input in_t t);
    result_t r;
    int      ref_ma;
    int      pct;
    r = '0;
    ref_ma = 0;
    if (t.func) cur_mode = t.new_mode;
    case (cur_mode)
      MODE_PWM: begin
        pct = open_pct;
        if (pct > PCT_LIMIT) pct = PCT_LIMIT;
        else if (pct < -PCT_LIMIT) pct = -PCT_LIMIT;
        r.direction = (pct <= 0);
        r.duty = DUTY_W'((pct < 0 ? -pct : pct) * 20);
      end
      MODE_TEST: begin
        if (test_cnt >= TEST_EDGE_3) ref_ma = -TEST_AMP;
        else if (test_cnt >= TEST_EDGE_2) ref_ma = TEST_AMP;
        else if (test_cnt >= TEST_EDGE_1) ref_ma = -TEST_AMP;
        else ref_ma = TEST_AMP;
        pi_drive(ref_ma, int'($signed(t.measured_ma)), r.duty, r.direction);
        r.test_index = CNT_W'(test_cnt);
        test_cnt = (test_cnt + 1) & 'h7f;
        // end of run: clear the integrator and fall back to idle
        if (test_cnt >= TEST_LEN) begin
          test_cnt = 0;
          integ = 0;
          cur_mode = MODE_IDLE;
          r.test_done = 1'b1;
        end
      end
      MODE_TRACK: begin
        ref_ma = int'($signed(t.target_ma));
        pi_drive(ref_ma, int'($signed(t.measured_ma)), r.duty, r.direction);
      end
      default: ;
    endcase
    r.mode_now = cur_mode;
    r.reference_ma = 16'(ref_ma);
    return r;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    results_seen++;
    if (got.test_done) runs_done++;
    if (expected_results.size() == 0) begin
      report_mismatch("result item with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    if (got.duty !== want.duty)
      report_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
    if (got.direction !== want.direction)
      report_mismatch($sformatf("direction %0b, want %0b", got.direction, want.direction));
    if (got.mode_now !== want.mode_now)
      report_mismatch($sformatf("mode_now %0d, want %0d", got.mode_now, want.mode_now));
    if (got.reference_ma !== want.reference_ma)
      report_mismatch($sformatf("reference_ma %0d, want %0d",
                                $signed(got.reference_ma), $signed(want.reference_ma)));
    if (got.test_index !== want.test_index)
      report_mismatch($sformatf("test_index %0d, want %0d", got.test_index, want.test_index));
    if (got.test_done !== want.test_done)
      report_mismatch($sformatf("test_done %0b, want %0b", got.test_done, want.test_done));
  endtask

  // Tick driver: hold the item until taken, then wait the drawn gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(control_tick(in_data));
        ticks_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_data <= tick_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = calm ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each item, then stall for the drawn count
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        recv_stall = calm ? 0 : $urandom_range(0, 19);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycles, expected_results.size());
      $display("[motor_current_pi_controller_unit] ERROR");
      $finish;
    end
  end

  task automatic queue_tick(input logic func, input mode_t m,
                            input logic [15:0] meas, input logic [15:0] tgt);
    in_t t;
    t.func = func;
    t.new_mode = m;
    t.measured_ma = meas;
    t.target_ma = tgt;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // Call at a rising edge; leaves cfg_valid high for the caller to drop
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN:     kp_q = int'($signed(data));
      REG_INTEGRAL_GAIN: ki_q = int'($signed(data));
      REG_OPEN_LOOP:     open_pct = int'($signed(data[7:0]));
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_idle();
    while (ticks_taken != ticks_queued || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain(input int span);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 2)) - 1);
      3: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [15:0] near(input int center, input int span);
    return 16'(center + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    int          rand_ticks;
    int          n;
    int          kind;
    int          level;
    logic [15:0] d;
    rand_ticks = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every mode, leaving and resuming a test run
    write_reg(REG_PROP_GAIN, 16'd256);
    write_reg(REG_INTEGRAL_GAIN, 16'd16);
    write_reg(REG_OPEN_LOOP, 16'h0080);     // -128, clamps to -100
    write_reg(REG_SPARE, 16'hffff);         // no such register
    cfg_valid <= 1'b0;
    queue_tick(1'b0, MODE_TRACK, 16'h7fff, 16'h8000);  // no load without func
    queue_tick(1'b1, MODE_PWM, 16'h8000, 16'h7fff);
    queue_tick(1'b1, MODE_TRACK, 16'h8000, 16'h7fff);
    queue_tick(1'b0, MODE_IDLE, 16'h7fff, 16'h8000);
    queue_tick(1'b0, MODE_IDLE, 16'h0000, 16'h0000);
    queue_tick(1'b1, MODE_TEST, 16'h0000, 16'h0000);
    repeat (3) queue_tick(1'b0, MODE_IDLE, 16'd150, 16'h0000);
    queue_tick(1'b1, MODE_TRACK, 16'd10, 16'd20);      // leave test mid-run
    queue_tick(1'b1, MODE_TEST, 16'hff00, 16'h0000);   // resume from kept count
    queue_tick(1'b1, MODE_IDLE, 16'hffff, 16'hffff);

    wait_idle();
    write_reg(REG_PROP_GAIN, 16'h8000);
    write_reg(REG_INTEGRAL_GAIN, 16'h7fff);
    write_reg(REG_OPEN_LOOP, 16'h007f);     // 127, clamps to 100
    cfg_valid <= 1'b0;
    queue_tick(1'b1, MODE_PWM, 16'h0000, 16'h0000);
    queue_tick(1'b1, MODE_TRACK, 16'd100, 16'hff9c);
    queue_tick(1'b0, MODE_IDLE, 16'hff9c, 16'd100);
    queue_tick(1'b1, MODE_TEST, 16'd200, 16'h0000);

    wait_idle();
    write_reg(REG_PROP_GAIN, 16'h7fff);
    write_reg(REG_INTEGRAL_GAIN, 16'h8000);
    write_reg(REG_OPEN_LOOP, 16'h0000);
    cfg_valid <= 1'b0;
    queue_tick(1'b1, MODE_PWM, 16'h0000, 16'h0000);
    queue_tick(1'b1, MODE_TRACK, 16'h0000, 16'h0001);
    queue_tick(1'b1, MODE_TEST, 16'hfed4, 16'h0000);

    wait_idle();
    write_reg(REG_PROP_GAIN, 16'h0000);
    write_reg(REG_INTEGRAL_GAIN, 16'h0000);
    write_reg(REG_OPEN_LOOP, 16'h0064);
    cfg_valid <= 1'b0;
    queue_tick(1'b1, MODE_PWM, 16'h1234, 16'h4321);
    queue_tick(1'b1, MODE_TRACK, 16'h0000, 16'h0000);

    wait_idle();
    write_reg(REG_OPEN_LOOP, 16'hff9c);
    cfg_valid <= 1'b0;
    queue_tick(1'b1, MODE_PWM, 16'h0000, 16'h0000);

    // Random phases: new settings each phase, then a few scenarios
    while (rand_ticks < RANDOM_TICKS) begin
      wait_idle();
      write_reg(REG_PROP_GAIN, pick_gain(64));
      write_reg(REG_INTEGRAL_GAIN, pick_gain(16));
      d = 16'($urandom);
      if ($urandom_range(0, 1)) d[7:0] = 8'(int'($urandom_range(0, 200)) - 100);
      write_reg(REG_OPEN_LOOP, d);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
      cfg_valid <= 1'b0;
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 5)) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          // test run, now and then cut short
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                          : TEST_LEN + $urandom_range(0, 4);
          queue_tick(1'b1, MODE_TEST, near(0, 400), 16'($urandom));
          repeat (n)
            queue_tick($urandom_range(0, 15) == 0, MODE_TEST, near(0, 400), 16'($urandom));
          rand_ticks += n + 1;
        end else if (kind < 7) begin
          // track a stepped target with the current nearby
          n = $urandom_range(5, 40);
          level = int'($urandom_range(0, 3000)) - 1500;
          queue_tick(1'b1, MODE_TRACK, near(level, 300), 16'(level));
          repeat (n) begin
            if ($urandom_range(0, 7) == 0) level = int'($urandom_range(0, 3000)) - 1500;
            queue_tick(1'b0, mode_t'($urandom_range(0, 3)), near(level, 300), 16'(level));
          end
          rand_ticks += n + 1;
        end else if (kind == 7) begin
          n = $urandom_range(2, 8);
          queue_tick(1'b1, $urandom_range(0, 1) ? MODE_PWM : MODE_IDLE,
                     16'($urandom), 16'($urandom));
          repeat (n)
            queue_tick(1'b0, mode_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
          rand_ticks += n + 1;
        end else begin
          n = $urandom_range(5, 20);
          repeat (n)
            queue_tick(1'($urandom), mode_t'($urandom_range(0, 3)),
                       16'($urandom), 16'($urandom));
          rand_ticks += n;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never came", expected_results.size()));
    $display("checked %0d results from %0d ticks across %0d register writes",
             results_seen, ticks_taken, cfg_writes);
    $display("all four modes exercised, %0d test runs finished, gains at extremes and small",
             runs_done);
    if (errors == 0) begin
      $display("[motor_current_pi_controller_unit] OK");
    end else begin
      $display("[motor_current_pi_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
